[src/sgne_pkg.sv]
// ----------------------------------------------------------------------------
// sgne_pkg: shared types and constants of the step grid to note events block
// Widths, command codes, the queue item format and the event format.
// ----------------------------------------------------------------------------
package sgne_pkg;

  localparam int MAX_NOTES   = 8;
  localparam int BAR_BITS    = 16;
  localparam int NOTE_IDX_W  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int COUNT_W     = $clog2(MAX_NOTES + 1);

  localparam int TIME_W      = 32;
  localparam int BPB_W       = 20;
  localparam int SPB_W       = 7;
  localparam int STEP_W      = 6;
  localparam int CHAN_W      = 4;
  localparam int NOTE_W      = 7;
  localparam int CMD_W       = 3;
  localparam int PITCH_W     = 9;
  localparam int VEL_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int SPB_MAX     = 64;
  localparam int DIVIDEND_W  = STEP_W + BPB_W;
  localparam int DIVISOR_W   = SPB_W;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);
  localparam int BAR_PROD_W  = BAR_BITS + BPB_W;
  localparam int SUM_W       = BAR_PROD_W + 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // Input command codes.
  localparam logic [CMD_W-1:0] CMD_REST    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUSTAIN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NOTE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHORD   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_END     = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEATS_PER_BAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_BAR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL   = 2'd3;

  typedef enum logic [2:0] {
    KIND_REST,
    KIND_SUSTAIN,
    KIND_NOTE,
    KIND_CHORD,
    KIND_END
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [NOTE_W-1:0]  pitch;
    logic [NOTE_W-1:0]  vel;
  } slot_t;

  typedef struct packed {
    logic [TIME_W-1:0]  start_position;
    logic [BPB_W-1:0]   beats_per_bar;
    logic [SPB_W-1:0]   steps_per_bar;
    logic [CHAN_W-1:0]  midi_channel;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [TIME_W-1:0]  event_time;
    logic               note_off;
    logic [CHAN_W-1:0]  channel;
    logic [NOTE_W-1:0]  note_number;
    logic [NOTE_W-1:0]  strength;
    logic               last_of_run;
    logic               dropped;
  } note_ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_OFF,
    ST_ON,
    ST_FIN,
    ST_CHORD
  } back_state_t;

endpackage

[src/sgne_front.sv]
// ----------------------------------------------------------------------------
// sgne_front: input side
// Accepts step items, clamps pitch and velocity and classifies the command.
// ----------------------------------------------------------------------------
module sgne_front (
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [sgne_pkg::CMD_W-1:0]    command,
  input  logic signed [sgne_pkg::PITCH_W-1:0] pitch,
  input  logic [sgne_pkg::VEL_W-1:0]    velocity,
  input  logic                          q_full,
  output logic                          push,
  output sgne_pkg::slot_t               slot
);
  import sgne_pkg::*;

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  always_comb begin
    case (command)
      CMD_SUSTAIN: slot.kind = KIND_SUSTAIN;
      CMD_NOTE:    slot.kind = KIND_NOTE;
      CMD_CHORD:   slot.kind = KIND_CHORD;
      CMD_END:     slot.kind = KIND_END;
      default:     slot.kind = KIND_REST;
    endcase

    if (pitch < 0) begin
      slot.pitch = '0;
    end else if (pitch > 9'sd127) begin
      slot.pitch = '1;
    end else begin
      slot.pitch = pitch[NOTE_W-1:0];
    end

    if (velocity == '0) begin
      slot.vel = NOTE_W'(1);
    end else if (velocity[VEL_W-1]) begin
      slot.vel = '1;
    end else begin
      slot.vel = velocity[NOTE_W-1:0];
    end
  end

endmodule

[src/sgne_queue.sv]
// ----------------------------------------------------------------------------
// sgne_queue: short item queue
// Two-entry queue that decouples the input side from the event sequencer.
// ----------------------------------------------------------------------------
module sgne_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sgne_pkg::slot_t  wr_slot,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output sgne_pkg::slot_t  head
);
  import sgne_pkg::*;

  slot_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wptr;
  logic [QPTR_W-1:0]    rptr;
  logic [QCOUNT_W-1:0]  count;

  assign full  = (count == QCOUNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wr_slot;
    end
  end

endmodule

[src/sgne_div.sv]
// ----------------------------------------------------------------------------
// sgne_div: step offset divider
// Restoring divider, one quotient bit per cycle, for the step offset in a bar.
// ----------------------------------------------------------------------------
module sgne_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [sgne_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [sgne_pkg::DIVISOR_W-1:0]    divisor,
  output logic                              done,
  output logic [sgne_pkg::DIVIDEND_W-1:0]   quotient
);
  import sgne_pkg::*;

  logic [DIVIDEND_W-1:0]  work;
  logic [DIVISOR_W-1:0]   rem;
  logic [DIVISOR_W-1:0]   dsr;
  logic [DIV_CNT_W-1:0]   cnt;
  logic                   busy;
  logic [DIVISOR_W:0]     rem_shift;
  logic [DIVISOR_W:0]     rem_sub;
  logic                   fits;

  // The remainder stays below the divisor, so the shifted value fits one
  // extra bit and the kept remainder fits the divisor width again.
  always_comb begin
    rem_shift = {rem, work[DIVIDEND_W-1]};
    fits      = (rem_shift >= {1'b0, dsr});
    rem_sub   = rem_shift - {1'b0, dsr};
  end

  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
      cnt  <= '0;
    end else if (busy) begin
      rem  <= fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      work <= {work[DIVIDEND_W-2:0], fits};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

[src/sgne_back.sv]
// ----------------------------------------------------------------------------
// sgne_back: event sequencer
// Keeps the step position and sounding notes, computes slot times and emits
// note-off and note-on events one per cycle, while the output is not stalled.
// ----------------------------------------------------------------------------
module sgne_back (
  input  logic                clk,
  input  logic                rst,
  input  sgne_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  sgne_pkg::slot_t     q_head,
  output logic                pop,
  input  logic                event_stall,
  output sgne_pkg::note_ev_t  ev
);
  import sgne_pkg::*;

  back_state_t            state;
  back_state_t            state_next;

  logic [BAR_BITS-1:0]    bar_index;
  logic [STEP_W-1:0]      step_in_bar;
  logic [NOTE_W-1:0]      sounding_pitches [MAX_NOTES];
  logic [COUNT_W-1:0]     sounding_count;
  logic                   chord_open;
  logic [TIME_W-1:0]      chord_time;

  slot_t                  cur;
  logic [COUNT_W-1:0]     off_idx;
  logic [BAR_PROD_W-1:0]  bar_prod;
  logic [TIME_W-1:0]      slot_time;

  logic                   div_start;
  logic                   div_done;
  logic [DIVIDEND_W-1:0]  div_quot;
  logic [DIVIDEND_W-1:0]  step_prod;
  logic [SPB_W-1:0]       spb;
  logic [SUM_W-1:0]       time_sum;

  logic                   slot_free;
  logic                   note_follows;
  logic                   store_full;
  logic                   out_load;
  logic                   time_load;
  logic                   do_advance;
  logic                   do_home;
  logic                   close_chord;
  logic                   clear_sound;
  logic                   start_chord;
  logic                   add_chord;
  logic                   off_inc;
  logic [STEP_W-1:0]      step_inc;

  note_ev_t               ld;

  always_comb begin
    if (cfg.steps_per_bar == '0) begin
      spb = SPB_W'(1);
    end else if (cfg.steps_per_bar > SPB_W'(SPB_MAX)) begin
      spb = SPB_W'(SPB_MAX);
    end else begin
      spb = cfg.steps_per_bar;
    end
  end

  assign step_prod = DIVIDEND_W'(step_in_bar * cfg.beats_per_bar);
  assign time_sum  = SUM_W'(cfg.start_position) + SUM_W'(bar_prod) + SUM_W'(div_quot);
  assign step_inc  = step_in_bar + 1'b1;

  sgne_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (step_prod),
    .divisor  (spb),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    slot_free    = !ev.valid || !event_stall;
    note_follows = (cur.kind == KIND_NOTE) && (cfg.beats_per_bar != '0);
    store_full   = (sounding_count >= COUNT_W'(MAX_NOTES));

    state_next  = state;
    pop         = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    time_load   = 1'b0;
    do_advance  = 1'b0;
    do_home     = 1'b0;
    close_chord = 1'b0;
    clear_sound = 1'b0;
    start_chord = 1'b0;
    add_chord   = 1'b0;
    off_inc     = 1'b0;

    ld.valid       = 1'b1;
    ld.event_time  = slot_time;
    ld.note_off    = 1'b0;
    ld.channel     = cfg.midi_channel;
    ld.note_number = cur.pitch;
    ld.strength    = cur.vel;
    ld.last_of_run = 1'b0;
    ld.dropped     = 1'b0;

    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (q_head.kind)
            KIND_SUSTAIN: begin
              close_chord = 1'b1;
              do_advance  = 1'b1;
            end
            KIND_CHORD: begin
              // A chord pitch with no open note slot is ignored.
              if (chord_open) begin
                state_next = ST_CHORD;
              end
            end
            default: begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        time_load  = 1'b1;
        state_next = ST_OFF;
      end
      ST_OFF: begin
        if (off_idx < sounding_count) begin
          if (slot_free) begin
            out_load       = 1'b1;
            off_inc        = 1'b1;
            ld.note_off    = 1'b1;
            ld.note_number = sounding_pitches[off_idx[NOTE_IDX_W-1:0]];
            ld.strength    = '0;
            ld.last_of_run = (off_idx + 1'b1 == sounding_count) && !note_follows;
          end
        end else begin
          clear_sound = 1'b1;
          state_next  = note_follows ? ST_ON : ST_FIN;
        end
      end
      ST_ON: begin
        if (slot_free) begin
          out_load       = 1'b1;
          ld.last_of_run = 1'b1;
          start_chord    = 1'b1;
          state_next     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (cur.kind == KIND_END) begin
          do_home = 1'b1;
        end else begin
          do_advance = 1'b1;
        end
        state_next = ST_IDLE;
      end
      ST_CHORD: begin
        if (slot_free) begin
          out_load       = 1'b1;
          ld.event_time  = chord_time;
          ld.last_of_run = 1'b1;
          ld.dropped     = store_full;
          add_chord      = !store_full;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Position, sounding count and chord state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bar_index      <= '0;
      step_in_bar    <= '0;
      sounding_count <= '0;
      chord_open     <= 1'b0;
      chord_time     <= '0;
    end else begin
      if (do_home) begin
        bar_index   <= '0;
        step_in_bar <= '0;
      end else if (do_advance) begin
        if ({1'b0, step_inc} >= spb) begin
          step_in_bar <= '0;
          if (bar_index != '1) begin
            bar_index <= bar_index + 1'b1;
          end
        end else begin
          step_in_bar <= step_inc;
        end
      end

      if (close_chord || clear_sound) begin
        chord_open <= 1'b0;
      end else if (start_chord) begin
        chord_open <= 1'b1;
        chord_time <= slot_time;
      end

      if (clear_sound) begin
        sounding_count <= '0;
      end else if (start_chord) begin
        sounding_count <= COUNT_W'(1);
      end else if (add_chord) begin
        sounding_count <= sounding_count + 1'b1;
      end
    end
  end

  // The sounding pitch store is never cleared; only entries below the
  // count are read.
  always_ff @(posedge clk) begin
    if (start_chord) begin
      sounding_pitches[0] <= cur.pitch;
    end else if (add_chord) begin
      sounding_pitches[sounding_count[NOTE_IDX_W-1:0]] <= cur.pitch;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= q_head;
      off_idx <= '0;
    end else if (off_inc) begin
      off_idx <= off_idx + 1'b1;
    end
    if (div_start) begin
      bar_prod <= BAR_PROD_W'(bar_index * cfg.beats_per_bar);
    end
    if (time_load) begin
      slot_time <= (|time_sum[SUM_W-1:TIME_W]) ? '1 : time_sum[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev.valid <= 1'b0;
    end else if (out_load) begin
      ev <= ld;
    end else if (!event_stall) begin
      ev.valid <= 1'b0;
    end
  end

endmodule

[src/step_grid_to_note_events.sv]
// A chord pitch item with an open note gives one event; a sustain item is consumed
// once it reaches the head of the queue and gives no event.
// A note, rest or end item waits on the step offset divider, then gives one event per
// cycle while the output is not stalled: note-offs for sounding notes, then a note-on
// for a note item with nonzero beats per bar. Items are handled one at a time.
// Reset (rst, synchronous) clears position, sounding count, queue and output valid;
// the sounding pitch store is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// step_grid_to_note_events: step sequencer slots to timed note events
// Front side classifies items, a short queue decouples it from the event
// sequencer, and configuration registers set timing and channel.
// ----------------------------------------------------------------------------
module step_grid_to_note_events (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sgne_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgne_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic [sgne_pkg::CMD_W-1:0]           command,
  input  logic signed [sgne_pkg::PITCH_W-1:0]  pitch,
  input  logic [sgne_pkg::VEL_W-1:0]           velocity,
  output logic                                 event_valid,
  input  logic                                 event_stall,
  output logic [sgne_pkg::TIME_W-1:0]          event_time,
  output logic                                 note_off,
  output logic [sgne_pkg::CHAN_W-1:0]          channel,
  output logic [sgne_pkg::NOTE_W-1:0]          note_number,
  output logic [sgne_pkg::NOTE_W-1:0]          strength,
  output logic                                 last_of_run,
  output logic                                 dropped
);
  import sgne_pkg::*;

  cfg_t      cfg;
  slot_t     front_slot;
  slot_t     q_head;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_empty;
  note_ev_t  ev;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_position <= '0;
      cfg.beats_per_bar  <= BPB_W'(16384);
      cfg.steps_per_bar  <= SPB_W'(16);
      cfg.midi_channel   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_POSITION: cfg.start_position <= cfg_data[TIME_W-1:0];
        CFG_BEATS_PER_BAR:  cfg.beats_per_bar  <= cfg_data[BPB_W-1:0];
        CFG_STEPS_PER_BAR:  cfg.steps_per_bar  <= cfg_data[SPB_W-1:0];
        CFG_MIDI_CHANNEL:   cfg.midi_channel   <= cfg_data[CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sgne_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .pitch      (pitch),
    .velocity   (velocity),
    .q_full     (q_full),
    .push       (push),
    .slot       (front_slot)
  );

  sgne_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_slot (front_slot),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  sgne_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .pop         (pop),
    .event_stall (event_stall),
    .ev          (ev)
  );

  assign event_valid = ev.valid;
  assign event_time  = ev.event_time;
  assign note_off    = ev.note_off;
  assign channel     = ev.channel;
  assign note_number = ev.note_number;
  assign strength    = ev.strength;
  assign last_of_run = ev.last_of_run;
  assign dropped     = ev.dropped;

endmodule
